FILE: sv/step_sequencer_with_durations_defines.svh
// assertion macros for the step sequencer
`ifndef STEP_SEQUENCER_WITH_DURATIONS_DEFINES_SVH
`define STEP_SEQUENCER_WITH_DURATIONS_DEFINES_SVH

`ifndef SYNTHESIS

// property that holds at every enabled clock edge
`define SSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define SSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SSD_ASSERT(lbl, clk, rstn, prop, msg)
`define SSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: sv/ssd_pkg.sv
// shared types and constants of the step sequencer
package ssd_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned ADDR_W     = 10;
  localparam int unsigned ENTRY_W    = 24;
  localparam int unsigned NOTE_OUT_W = 24;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned SPU_W      = 24;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned FRAC_W     = 8;

  // register reset values
  localparam logic [LEN_W-1:0] NOTE_LEN_RST = 11'd3;
  localparam logic [LEN_W-1:0] DUR_LEN_RST  = 11'd3;
  localparam logic [SPU_W-1:0] SPU_RST      = 24'd45158;

  // item operations
  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 2'd0,
    OP_TRIGGER  = 2'd1,
    OP_WR_NOTE  = 2'd2,
    OP_WR_DUR   = 2'd3
  } op_e;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LEN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_LEN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPU      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL   = 4'd3;

  typedef struct packed {
    op_e               opcode;
    logic [ADDR_W-1:0] table_address;
    logic [ENTRY_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [NOTE_OUT_W-1:0] note_value;
    logic                  step_started;
    logic                  bar_start;
  } out_item_t;

endpackage

FILE: sv/ssd_in_if.sv
// input channel of the step sequencer
interface ssd_in_if import ssd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/ssd_out_if.sv
// result channel of the step sequencer
interface ssd_out_if import ssd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/step_sequencer_with_durations.sv
// top level of the step sequencer with per-step durations
// an accepted transaction passes through the input register and then the result register
// throughput: one transaction per cycle, sustained while the result side takes them
// the table entries for the next step are prefetched from each table's single read
// port, addressed from the next index state, so consecutive steps need no wait
// reset: control state and registers return to their reset values at once; tables
// hold their contents and need a write before they are read
`include "step_sequencer_with_durations_defines.svh"

module step_sequencer_with_durations import ssd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH    = 1024,
  parameter int unsigned NOTE_WIDTH     = 24,
  parameter int unsigned DURATION_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ssd_in_if.sink                in_i,
  ssd_out_if.source             out_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned PROD_W = DURATION_WIDTH + SPU_W;

  // last used index for a length register value, clamped to the table
  function automatic logic [IDX_W-1:0] last_idx(input logic [LEN_W-1:0] len);
    logic [31:0] l;
    l = 32'(len);
    if (l < 32'd2) begin
      l = 32'd2;
    end
    if (l > 32'(TABLE_DEPTH)) begin
      l = 32'(TABLE_DEPTH);
    end
    return IDX_W'(l - 32'd1);
  endfunction

  // registers
  logic [LEN_W-1:0]          note_len_q, note_len_d;
  logic [LEN_W-1:0]          dur_len_q, dur_len_d;
  logic [SPU_W-1:0]          spu_q, spu_d;
  logic                      manual_q, manual_d;

  // sequencer state
  logic [COUNT_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]          note_idx_q, note_idx_d;
  logic [IDX_W-1:0]          dur_idx_q, dur_idx_d;
  logic [NOTE_WIDTH-1:0]     held_q, held_d;
  logic                      trig_q, trig_d;

  // pipeline registers
  logic                      in_valid_q, in_valid_d;
  in_item_t                  in_q;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  logic                      proc_fire;
  logic                      in_fire;
  logic                      addr_ok;

  logic [IDX_W-1:0]          note_last_q, dur_last_q;
  logic [IDX_W-1:0]          note_last_d, dur_last_d;
  logic [IDX_W-1:0]          note_next, dur_next;
  logic                      note_wrap, dur_wrap;
  logic [IDX_W-1:0]          note_raddr, dur_raddr;

  logic                      note_we, dur_we;
  logic [NOTE_WIDTH-1:0]     rd_note;
  logic [DURATION_WIDTH-1:0] rd_dur;

  logic [PROD_W-1:0]         prod;
  logic [63:0]               prod_sh;
  logic [COUNT_W-1:0]        reload;

  // handshake: the input register is refilled while its item is processed
  assign proc_fire   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || proc_fire;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // cyclic advance of both indices
  assign note_last_q = last_idx(note_len_q);
  assign dur_last_q  = last_idx(dur_len_q);
  assign note_wrap   = (note_idx_q >= note_last_q);
  assign dur_wrap    = (dur_idx_q >= dur_last_q);
  assign note_next   = note_wrap ? '0 : note_idx_q + IDX_W'(1);
  assign dur_next    = dur_wrap ? '0 : dur_idx_q + IDX_W'(1);

  // step reload: duration times 16.8 factor, truncated and saturated
  assign prod    = PROD_W'(rd_dur) * PROD_W'(spu_q);
  assign prod_sh = 64'(prod) >> FRAC_W;
  assign reload  = (prod_sh > 64'h0000_0000_FFFF_FFFF) ? '1 : prod_sh[COUNT_W-1:0];

  assign addr_ok = (32'(in_q.table_address) < 32'(TABLE_DEPTH));

  // item processing and register writes
  always_comb begin
    note_len_d = note_len_q;
    dur_len_d  = dur_len_q;
    spu_d      = spu_q;
    manual_d   = manual_q;
    cnt_d      = cnt_q;
    note_idx_d = note_idx_q;
    dur_idx_d  = dur_idx_q;
    held_d     = held_q;
    trig_d     = trig_q;
    note_we    = 1'b0;
    dur_we     = 1'b0;
    out_d.step_started = 1'b0;
    out_d.bar_start    = 1'b0;

    if (proc_fire) begin
      unique case (in_q.opcode)
        OP_TICK: begin
          if (manual_q) begin
            if (trig_q) begin
              trig_d             = 1'b0;
              note_idx_d         = note_next;
              out_d.bar_start    = note_wrap;
              held_d             = rd_note;
              out_d.step_started = 1'b1;
            end
          end else if (cnt_q == '0) begin
            note_idx_d         = note_next;
            dur_idx_d          = dur_next;
            out_d.bar_start    = note_wrap;
            cnt_d              = reload;
            held_d             = rd_note;
            out_d.step_started = 1'b1;
          end else begin
            cnt_d = cnt_q - COUNT_W'(1);
          end
        end
        OP_TRIGGER: trig_d  = 1'b1;
        OP_WR_NOTE: note_we = addr_ok;
        OP_WR_DUR:  dur_we  = addr_ok;
        default: ;
      endcase
    end

    // register writes, a length write also rewinds its index
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NOTE_LEN: begin
          note_len_d = cfg_wdata_i[LEN_W-1:0];
          note_idx_d = last_idx(cfg_wdata_i[LEN_W-1:0]);
        end
        CFG_DUR_LEN: begin
          dur_len_d = cfg_wdata_i[LEN_W-1:0];
          dur_idx_d = last_idx(cfg_wdata_i[LEN_W-1:0]);
        end
        CFG_SPU:    spu_d    = cfg_wdata_i[SPU_W-1:0];
        CFG_MANUAL: manual_d = cfg_wdata_i[0];
        default: ;
      endcase
    end

    out_d.note_value = NOTE_OUT_W'(held_d);
  end

  // prefetch address: the entry after the index the state moves to
  assign note_last_d = last_idx(note_len_d);
  assign dur_last_d  = last_idx(dur_len_d);
  assign note_raddr  = (note_idx_d >= note_last_d) ? '0 : note_idx_d + IDX_W'(1);
  assign dur_raddr   = (dur_idx_d >= dur_last_d) ? '0 : dur_idx_d + IDX_W'(1);

  // handshake register next values
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (proc_fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_len_q  <= NOTE_LEN_RST;
      dur_len_q   <= DUR_LEN_RST;
      spu_q       <= SPU_RST;
      manual_q    <= 1'b0;
      cnt_q       <= '0;
      note_idx_q  <= last_idx(NOTE_LEN_RST);
      dur_idx_q   <= last_idx(DUR_LEN_RST);
      held_q      <= '0;
      trig_q      <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      note_len_q  <= note_len_d;
      dur_len_q   <= dur_len_d;
      spu_q       <= spu_d;
      manual_q    <= manual_d;
      cnt_q       <= cnt_d;
      note_idx_q  <= note_idx_d;
      dur_idx_q   <= dur_idx_d;
      held_q      <= held_d;
      trig_q      <= trig_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_i.data;
    end
    if (proc_fire) begin
      out_q <= out_d;
    end
  end

  // note and duration tables
  ssd_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (NOTE_WIDTH)
  ) u_note_ram (
    .clk_i   (clk_i),
    .we_i    (note_we),
    .waddr_i (IDX_W'(in_q.table_address)),
    .wdata_i (NOTE_WIDTH'(in_q.entry_value)),
    .raddr_i (note_raddr),
    .rdata_o (rd_note)
  );

  ssd_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (DURATION_WIDTH)
  ) u_dur_ram (
    .clk_i   (clk_i),
    .we_i    (dur_we),
    .waddr_i (IDX_W'(in_q.table_address)),
    .wdata_i (DURATION_WIDTH'(in_q.entry_value)),
    .raddr_i (dur_raddr),
    .rdata_o (rd_dur)
  );

  // checks
  `SSD_ASSERT(a_note_idx_range, clk_i, rst_ni, (note_idx_q <= note_last_q), "note index past length")
  `SSD_ASSERT_NEXT(a_cnt_dec, clk_i, rst_ni, (proc_fire && (in_q.opcode == OP_TICK) && !manual_q && (cnt_q != '0)), (cnt_q == $past(cnt_q) - COUNT_W'(1)), "countdown did not decrement")
  `SSD_ASSERT_NEXT(a_trig_used, clk_i, rst_ni, (proc_fire && (in_q.opcode == OP_TICK) && manual_q && trig_q), (!trig_q && out_valid_q && out_q.step_started), "manual trigger not consumed")
  `SSD_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, (in_valid_q && !proc_fire), in_valid_q, "stalled transaction lost")

endmodule

FILE: sv/ssd_table_ram.sv
// table memory with registered read and write-to-read forwarding
module ssd_table_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, a same-cycle write to the read address is passed through
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/tb.sv
// self-checking testbench for the step sequencer with per-step durations
`timescale 1ns / 100ps

module tb;
  import ssd_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  // entries loaded at the start; no test steps an index past them
  localparam int unsigned LOAD_DEPTH  = 128;
  localparam int unsigned DRAIN_EXTRA = 4;
  // index that maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ssd_in_if  in_ch ();
  ssd_out_if out_ch ();

  step_sequencer_with_durations uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always #6 clk_i = ~clk_i;

  // sequencer state as the testbench tracks it
  logic [NOTE_OUT_W-1:0] note_mem [DEPTH];
  logic [15:0]           dur_mem [DEPTH];
  logic [LEN_W-1:0]      cfg_note_len;
  logic [LEN_W-1:0]      cfg_dur_len;
  logic [SPU_W-1:0]      cfg_spu;
  logic                  cfg_manual;
  logic [COUNT_W-1:0]    samples_left;
  logic [ADDR_W-1:0]     note_pos;
  logic [ADDR_W-1:0]     dur_pos;
  logic [NOTE_OUT_W-1:0] cur_note;
  logic                  trig_armed;

  out_item_t   notes_due [$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned rx_cycle;

  // length register as the block uses it
  function automatic int unsigned eff_len(logic [LEN_W-1:0] len);
    if (len < 2) return 2;
    if (len > DEPTH) return DEPTH;
    return len;
  endfunction

  // cyclic successor of a table index; zero means a wrap
  function automatic logic [ADDR_W-1:0] next_pos(logic [ADDR_W-1:0] pos,
                                                  logic [LEN_W-1:0] len);
    int unsigned n;
    n = pos + 1;
    if (n >= eff_len(len)) return '0;
    return ADDR_W'(n);
  endfunction

  // expected result of one transaction, updating the tracked state
  function automatic out_item_t advance_sequencer(in_item_t it);
    out_item_t res;
    logic [39:0] reload;
    res = '0;
    case (it.opcode)
      OP_TICK: begin
        if (cfg_manual) begin
          if (trig_armed) begin
            trig_armed = 1'b0;
            note_pos = next_pos(note_pos, cfg_note_len);
            res.bar_start = (note_pos == '0);
            cur_note = note_mem[note_pos];
            res.step_started = 1'b1;
          end
        end else if (samples_left == '0) begin
          note_pos = next_pos(note_pos, cfg_note_len);
          res.bar_start = (note_pos == '0);
          dur_pos = next_pos(dur_pos, cfg_dur_len);
          // 16-bit duration times 24-bit factor never exceeds 32 bits after the shift
          reload = 40'(dur_mem[dur_pos]) * 40'(cfg_spu);
          samples_left = reload[39:FRAC_W];
          cur_note = note_mem[note_pos];
          res.step_started = 1'b1;
        end else begin
          samples_left = samples_left - 1;
        end
      end
      OP_TRIGGER: trig_armed = 1'b1;
      OP_WR_NOTE: note_mem[it.table_address] = it.entry_value;
      OP_WR_DUR:  dur_mem[it.table_address] = it.entry_value[15:0];
      default: ;
    endcase
    res.note_value = cur_note;
    return res;
  endfunction

  function automatic in_item_t mk_item(op_e op, logic [ADDR_W-1:0] addr,
                                       logic [ENTRY_W-1:0] value);
    in_item_t it;
    it.opcode = op;
    it.table_address = addr;
    it.entry_value = value;
    return it;
  endfunction

  // random transaction; short durations unless long ones are harmless
  function automatic in_item_t random_item(int unsigned tick_pct, int unsigned trig_pct,
                                           bit long_dur);
    in_item_t it;
    int unsigned roll;
    it.table_address = ADDR_W'($urandom);
    it.entry_value = ENTRY_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      it.opcode = OP_TICK;
    end else if (roll < tick_pct + trig_pct) begin
      it.opcode = OP_TRIGGER;
    end else if (roll[0]) begin
      it.opcode = OP_WR_NOTE;
    end else begin
      it.opcode = OP_WR_DUR;
      if (!long_dur) it.entry_value[15:0] = 16'($urandom_range(0, 3));
    end
    return it;
  endfunction

  // send one transaction, with bursts and gaps on the input side
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    notes_due.push_back(advance_sequencer(it));
    burst_left--;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (notes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_EXTRA) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count, int unsigned tick_pct,
                            int unsigned trig_pct, bit long_dur);
    repeat (count) send_item(random_item(tick_pct, trig_pct, long_dur));
  endtask

  // register write; the caller lowers the enable after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_NOTE_LEN: begin
        cfg_note_len = data[LEN_W-1:0];
        note_pos = ADDR_W'(eff_len(cfg_note_len) - 1);
      end
      CFG_DUR_LEN: begin
        cfg_dur_len = data[LEN_W-1:0];
        dur_pos = ADDR_W'(eff_len(cfg_dur_len) - 1);
      end
      CFG_SPU:    cfg_spu = data[SPU_W-1:0];
      CFG_MANUAL: cfg_manual = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [LEN_W-1:0] nl, input logic [LEN_W-1:0] dl,
                            input logic [SPU_W-1:0] spu, input bit manual);
    write_reg(CFG_NOTE_LEN, CFG_DATA_W'(nl));
    write_reg(CFG_DUR_LEN, CFG_DATA_W'(dl));
    write_reg(CFG_SPU, CFG_DATA_W'(spu));
    write_reg(CFG_MANUAL, CFG_DATA_W'(manual));
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // load the low entries of both tables so no step ever reads an unwritten entry
  task automatic test_table_load();
    logic [ENTRY_W-1:0] value;
    for (int i = 0; i < LOAD_DEPTH; i++) begin
      value = (i == 0) ? '0 : (i == 1) ? '1 : ENTRY_W'($urandom);
      send_item(mk_item(OP_WR_NOTE, ADDR_W'(i), value));
    end
    // first three durations zero so the default tempo steps on every tick
    for (int i = 0; i < LOAD_DEPTH; i++) begin
      value = ENTRY_W'($urandom);
      value[15:0] = (i < 3) ? 16'd0 : 16'($urandom_range(0, 3));
      send_item(mk_item(OP_WR_DUR, ADDR_W'(i), value));
    end
    stop_sending();
    wait_drain();
  endtask

  // default registers; a trigger in auto mode stays pending
  task automatic test_reset_settings();
    send_item(mk_item(OP_TICK, '0, '0));
    send_item(mk_item(OP_TICK, '1, '1));
    send_item(mk_item(OP_TRIGGER, '0, '0));
    send_item(mk_item(OP_TICK, '0, '0));
    send_item(mk_item(OP_TICK, '0, '0));
    stop_sending();
    wait_drain();
  endtask

  // lengths below two act as two; zero duration steps again at once
  task automatic test_short_tables();
    set_config(11'd0, 11'd1, 24'd256, 1'b0);
    repeat (3) send_item(mk_item(OP_TICK, '0, '0));
    send_item(mk_item(OP_WR_DUR, 10'd1, 24'hFF0002));
    repeat (4) send_item(mk_item(OP_TICK, '0, '0));
    send_item(mk_item(OP_WR_NOTE, '1, '1));
    send_item(mk_item(OP_WR_DUR, '1, 24'hFF0003));
    stop_sending();
    wait_drain();
  endtask

  // manual mode consumes the pending trigger; repeated triggers merge
  task automatic test_manual_steps();
    set_config(11'd3, 11'd3, 24'd256, 1'b1);
    send_item(mk_item(OP_TICK, '0, '0));
    send_item(mk_item(OP_TICK, '0, '0));
    send_item(mk_item(OP_TRIGGER, '1, '1));
    send_item(mk_item(OP_TRIGGER, '0, '0));
    send_item(mk_item(OP_TICK, '0, '0));
    send_item(mk_item(OP_TICK, '0, '0));
    stop_sending();
    wait_drain();
  endtask

  // auto mode at a fast tempo; the receiver holds off long at the start
  task automatic test_auto_random();
    set_config(11'($urandom_range(2, 8)), 11'($urandom_range(2, 8)),
               24'($urandom_range(0, 512)), 1'b0);
    hold_request = 150;
    run_random(240, 60, 10, 1'b0);
    stop_sending();
    wait_drain();
  endtask

  // manual mode; the sender pauses halfway until all results are back
  task automatic test_manual_random();
    set_config(11'($urandom_range(2, 6)), 11'($urandom_range(2, 6)), 24'd256, 1'b1);
    run_random(90, 45, 30, 1'b0);
    stop_sending();
    wait_drain();
    run_random(90, 45, 30, 1'b0);
    stop_sending();
    wait_drain();
  endtask

  // longest tables with zero factor, so every tick steps and durations may be large;
  // fewer ticks than loaded entries keep the indices inside the loaded range
  task automatic test_full_tables();
    set_config(11'h7FF, 11'd1024, 24'd0, 1'b0);
    run_random(120, 60, 10, 1'b1);
    stop_sending();
    wait_drain();
  endtask

  // largest factor: one step, then a countdown that outlasts the run
  task automatic test_slow_tempo();
    set_config(11'd3, 11'd2, 24'hFFFFFF, 1'b0);
    send_item(mk_item(OP_WR_DUR, 10'd0, 24'h00FFFF));
    run_random(60, 60, 10, 1'b1);
    stop_sending();
    wait_drain();
  endtask

  // result side: stall pattern plus an optional long hold-off
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
        2:       out_ch.ready <= (rx_cycle % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (notes_due.size() == 0) begin
        $error("unexpected result: note_value %h", out_ch.data.note_value);
        mismatch_count++;
      end else begin
        exp_res = notes_due.pop_front();
        if (out_ch.data.note_value !== exp_res.note_value) begin
          $error("note_value: expected %h, got %h", exp_res.note_value,
                 out_ch.data.note_value);
          mismatch_count++;
        end
        if (out_ch.data.step_started !== exp_res.step_started) begin
          $error("step_started: expected %b, got %b", exp_res.step_started,
                 out_ch.data.step_started);
          mismatch_count++;
        end
        if (out_ch.data.bar_start !== exp_res.bar_start) begin
          $error("bar_start: expected %b, got %b", exp_res.bar_start,
                 out_ch.data.bar_start);
          mismatch_count++;
        end
      end
    end
  end

  // safety net against a hung block
  initial begin
    #12_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    rx_cycle = 0;
    hold_request = 0;
    hold_left = 0;
    burst_left = 0;
    mismatch_count = 0;
    cfg_note_len = NOTE_LEN_RST;
    cfg_dur_len = DUR_LEN_RST;
    cfg_spu = SPU_RST;
    cfg_manual = 1'b0;
    samples_left = '0;
    note_pos = ADDR_W'(eff_len(NOTE_LEN_RST) - 1);
    dur_pos = ADDR_W'(eff_len(DUR_LEN_RST) - 1);
    cur_note = '0;
    trig_armed = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_load();
    test_reset_settings();
    test_short_tables();
    test_manual_steps();
    test_auto_random();
    test_manual_random();
    test_full_tables();
    test_slow_tempo();

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
